@@ src/gcbd_pkg.sv @@
// ----------------------------------------------------------------------------
// gcbd_pkg
// Shared types, sizes and the linearising table of the gamma-correct 2x2
// box downsampler.
// ----------------------------------------------------------------------------
package gcbd_pkg;

   localparam int PIX_W         = 32;
   localparam int CFG_W         = 13;
   localparam int LIN_W         = 24;
   localparam int SUM_W         = 26;
   localparam int GAMMA_BITS    = 8;
   localparam int DEF_MAX_WIDTH = 4096;
   localparam int MAX_HEIGHT    = 4096;

   typedef enum logic {
      REG_SRC_WIDTH  = 1'b0,
      REG_SRC_HEIGHT = 1'b1
   } csr_reg_type;

   // Two source rows by two columns, ready for the encoder.
   typedef struct packed {
      logic [PIX_W-1:0] top_left;
      logic [PIX_W-1:0] top_right;
      logic [PIX_W-1:0] bot_left;
      logic [PIX_W-1:0] bot_right;
      logic             last;
   } quad_type;

   typedef logic [255:0][LIN_W-1:0] lin_rom_type;

   // L(v) = round(v^2.2 * 64): the n with (2n-1)^5 <= 2^35 * v^11 < (2n+1)^5.
   function automatic lin_rom_type build_lin_rom();
      lin_rom_type     rom;
      logic [127:0]    t;
      logic [127:0]    p;
      logic [127:0]    q;
      logic [LIN_W:0]  lo;
      logic [LIN_W:0]  hi;
      logic [LIN_W:0]  mid;
      for (int v = 0; v < 256; v++) begin
         t = 128'd1;
         for (int i = 0; i < 11; i++) begin
            t = t * 128'(v);
         end
         t  = t << 35;
         lo = '0;
         hi = (LIN_W+1)'(24'hFF_FFFF);
         for (int it = 0; it < LIN_W + 2; it++) begin
            if (lo < hi) begin
               mid = lo + ((hi - lo + 1'b1) >> 1);
               q   = 128'({mid, 1'b0}) - 128'd1;
               p   = q * q * q * q * q;
               if (p <= t) begin
                  lo = mid;
               end else begin
                  hi = mid - 1'b1;
               end
            end
         end
         rom[v] = lo[LIN_W-1:0];
      end
      return rom;
   endfunction

   localparam lin_rom_type LIN_ROM = build_lin_rom();

endpackage

@@ src/gcbd_ram.sv @@
// ----------------------------------------------------------------------------
// gcbd_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module gcbd_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 2048,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      // hold the last read word until the next read
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/gcbd_encode.sv @@
// ----------------------------------------------------------------------------
// gcbd_encode
// Linearise, sum and re-encode one 2x2 block; eight-stage bitwise search for
// the output byte of each colour channel.
// ----------------------------------------------------------------------------
module gcbd_encode import gcbd_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  quad_type         in_quad,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [PIX_W-1:0] out_pixel,
   output logic             out_last
);

   localparam int NCH = 3;

   typedef struct packed {
      logic [NCH-1:0][SUM_W-1:0]      sum;
      logic [NCH-1:0][GAMMA_BITS-1:0] k;
      logic [7:0]                     alpha;
      logic                           last;
   } srch_type;

   // first stage: table lookups and pair sums
   logic                           p1_vld_ff;
   logic [NCH-1:0][LIN_W:0]        p1_top_ff;
   logic [NCH-1:0][LIN_W:0]        p1_bot_ff;
   logic [9:0]                     p1_alpha_ff;
   logic                           p1_last_ff;
   logic [NCH-1:0][LIN_W:0]        p1_top_in;
   logic [NCH-1:0][LIN_W:0]        p1_bot_in;
   logic [9:0]                     p1_alpha_in;
   logic                           p1_acc;

   // search stages; stage 0 holds the full sums, stage GAMMA_BITS is the output
   logic                           srch_vld_ff [GAMMA_BITS+1];
   srch_type                       srch_ff     [GAMMA_BITS+1];
   srch_type                       srch_in     [GAMMA_BITS+1];
   logic [GAMMA_BITS:0]            srch_acc;

   always_comb begin
      for (int ch = 0; ch < NCH; ch++) begin
         p1_top_in[ch] = {1'b0, LIN_ROM[in_quad.top_left[8*ch +: 8]]}
                       + {1'b0, LIN_ROM[in_quad.top_right[8*ch +: 8]]};
         p1_bot_in[ch] = {1'b0, LIN_ROM[in_quad.bot_left[8*ch +: 8]]}
                       + {1'b0, LIN_ROM[in_quad.bot_right[8*ch +: 8]]};
      end
      p1_alpha_in = {2'b00, in_quad.top_left[31:24]} + {2'b00, in_quad.top_right[31:24]}
                  + {2'b00, in_quad.bot_left[31:24]} + {2'b00, in_quad.bot_right[31:24]};
   end

   // a stage takes new data when it is empty or its content moves on
   always_comb begin
      srch_acc[GAMMA_BITS] = !srch_vld_ff[GAMMA_BITS] || out_ready;
      for (int s = GAMMA_BITS - 1; s >= 0; s--) begin
         srch_acc[s] = !srch_vld_ff[s] || srch_acc[s+1];
      end
   end

   assign p1_acc   = !p1_vld_ff || srch_acc[0];
   assign in_ready = p1_acc;

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_vld_ff <= 1'b0;
      end else if (p1_acc) begin
         p1_vld_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (p1_acc) begin
         p1_top_ff   <= p1_top_in;
         p1_bot_ff   <= p1_bot_in;
         p1_alpha_ff <= p1_alpha_in;
         p1_last_ff  <= in_quad.last;
      end
   end

   // next value of every search stage
   always_comb begin
      srch_type              nx;
      logic [GAMMA_BITS-1:0] cand;
      nx = '0;
      for (int ch = 0; ch < NCH; ch++) begin
         nx.sum[ch] = {1'b0, p1_top_ff[ch]} + {1'b0, p1_bot_ff[ch]};
      end
      nx.alpha   = p1_alpha_ff[9:2];
      nx.last    = p1_last_ff;
      srch_in[0] = nx;
      for (int s = 1; s <= GAMMA_BITS; s++) begin
         nx = srch_ff[s-1];
         for (int ch = 0; ch < NCH; ch++) begin
            cand = nx.k[ch] | (GAMMA_BITS'(1) << (GAMMA_BITS - s));
            if ({LIN_ROM[cand], 2'b00} <= nx.sum[ch]) begin
               nx.k[ch] = cand;
            end
         end
         srch_in[s] = nx;
      end
   end

   for (genvar s = 0; s <= GAMMA_BITS; s++) begin : g_srch
      logic prev_vld;
      if (s == 0) begin : g_first
         assign prev_vld = p1_vld_ff;
      end else begin : g_next
         assign prev_vld = srch_vld_ff[s-1];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            srch_vld_ff[s] <= 1'b0;
         end else if (srch_acc[s]) begin
            srch_vld_ff[s] <= prev_vld;
         end
      end

      always_ff @(posedge clock) begin
         if (srch_acc[s]) begin
            srch_ff[s] <= srch_in[s];
         end
      end
   end

   assign out_valid = srch_vld_ff[GAMMA_BITS];
   assign out_pixel = {srch_ff[GAMMA_BITS].alpha, srch_ff[GAMMA_BITS].k};
   assign out_last  = srch_ff[GAMMA_BITS].last;

endmodule

@@ src/gamma_correct_box_downsample_2x2_unit.sv @@
// ----------------------------------------------------------------------------
// gamma_correct_box_downsample_2x2_unit
// Gamma-correct 2x2 box downsampler for RGBA8 raster streams.
//
// Feed source pixels in raster order, one request per pixel, at up to one
// request per clock; results leave at up to one per clock. Each 2x2 block
// gives one pixel: R, G and B are linearised through a 256-entry table
// (v^2.2 in 24-bit fixed point with 6 fraction bits), summed over the block
// and re-encoded as the largest byte whose linear value times four does not
// exceed the sum; alpha is the plain average, rounded down. frame_last marks
// the final result of a frame. A result passes from the request that
// completes its block through the line-store read, the table lookups, the
// final sum and the bit-by-bit search of the output byte, each registered.
// A trailing odd column or row is consumed and dropped, and a width or height
// below two consumes requests without producing anything. Program src_width
// (address 0) and src_height (address 4) while the stream is idle; a write
// keeps its low 13 bits, and values above the maximum saturate. The line
// store needs no clearing pass, so the block is ready straight out of reset.
// ----------------------------------------------------------------------------
module gamma_correct_box_downsample_2x2_unit import gcbd_pkg::*; #(
   parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
   input  logic             clock,
   input  logic             reset,
   // source pixel requests
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [PIX_W-1:0] req_src_pixel,
   // downsampled pixels
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [PIX_W-1:0] rsp_out_pixel,
   output logic             rsp_frame_last,
   // register port
   input  logic             csr_psel,
   input  logic             csr_penable,
   input  logic             csr_pwrite,
   input  logic [2:0]       csr_paddr,
   input  logic [31:0]      csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   localparam int PAIR_DEPTH = MAX_WIDTH / 2;
   localparam int PAIR_AW    = (PAIR_DEPTH > 1) ? $clog2(PAIR_DEPTH) : 1;

   logic [CFG_W-1:0]   src_width_ff;
   logic [CFG_W-1:0]   src_height_ff;
   logic [CFG_W-1:0]   col_ff;
   logic [CFG_W-1:0]   row_ff;
   logic [CFG_W-1:0]   col_in;
   logic [CFG_W-1:0]   row_in;
   logic [PIX_W-1:0]   left_ff;

   logic               csr_wr;
   csr_reg_type        csr_sel;

   logic [CFG_W-1:0]   width_even;
   logic [CFG_W-1:0]   height_even;
   logic               active;
   logic               in_area;
   logic               produce;
   logic               store_top;
   logic               is_last;
   logic               accept;
   logic [CFG_W:0]     col_inc;
   logic [CFG_W:0]     row_inc;

   // read stage: bottom pair waits here while the top pair is fetched
   logic               rd_vld_ff;
   logic [PIX_W-1:0]   rd_left_ff;
   logic [PIX_W-1:0]   rd_right_ff;
   logic               rd_last_ff;
   logic               rd_acc;

   logic [PAIR_AW-1:0] pair_addr;
   logic [2*PIX_W-1:0] pair_rd_data;

   quad_type           enc_quad;
   logic               enc_ready;

   // ------------------------------------------------------------------
   // Register port: always ready, register picked by address bit 2
   // ------------------------------------------------------------------
   assign csr_pready = 1'b1;
   assign csr_sel    = csr_reg_type'(csr_paddr[2]);
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         src_width_ff  <= '0;
         src_height_ff <= '0;
      end else if (csr_wr) begin
         unique case (csr_sel)
            REG_SRC_WIDTH: begin
               // saturate to the line store's reach
               if (32'(csr_pwdata[CFG_W-1:0]) > 32'(MAX_WIDTH)) begin
                  src_width_ff <= CFG_W'(MAX_WIDTH);
               end else begin
                  src_width_ff <= csr_pwdata[CFG_W-1:0];
               end
            end
            REG_SRC_HEIGHT: begin
               if (32'(csr_pwdata[CFG_W-1:0]) > 32'(MAX_HEIGHT)) begin
                  src_height_ff <= CFG_W'(MAX_HEIGHT);
               end else begin
                  src_height_ff <= csr_pwdata[CFG_W-1:0];
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (csr_sel)
         REG_SRC_WIDTH:  csr_prdata = 32'(src_width_ff);
         REG_SRC_HEIGHT: csr_prdata = 32'(src_height_ff);
         default:        csr_prdata = '0;
      endcase
   end

   // ------------------------------------------------------------------
   // Position tracking
   // ------------------------------------------------------------------
   // the cropped even area; a dimension below two disables the block
   assign width_even  = {src_width_ff[CFG_W-1:1], 1'b0};
   assign height_even = {src_height_ff[CFG_W-1:1], 1'b0};
   assign active      = (width_even != '0) && (height_even != '0);
   assign in_area     = active && (col_ff < width_even) && (row_ff < height_even);

   // odd column of an odd row closes a block; odd column of an even row
   // completes a top pair
   assign produce   = in_area && col_ff[0] && row_ff[0];
   assign store_top = in_area && col_ff[0] && !row_ff[0];
   assign is_last   = (col_ff == width_even - 1'b1) && (row_ff == height_even - 1'b1);

   // only a closing pixel needs room further down the pipe
   assign req_ready = !produce || rd_acc;
   assign accept    = req_valid && req_ready;

   always_comb begin
      col_inc = {1'b0, col_ff} + 1'b1;
      row_inc = {1'b0, row_ff} + 1'b1;
      col_in  = col_inc[CFG_W-1:0];
      row_in  = row_ff;
      // wrap at the programmed size, also after a shrink mid-frame
      if (col_inc >= {1'b0, src_width_ff}) begin
         col_in = '0;
         row_in = row_inc[CFG_W-1:0];
         if (row_inc >= {1'b0, src_height_ff}) begin
            row_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         row_ff  <= '0;
         left_ff <= '0;
      end else if (accept && active) begin
         col_ff <= col_in;
         row_ff <= row_in;
         if (in_area && !col_ff[0]) begin
            left_ff <= req_src_pixel;
         end
      end
   end

   // ------------------------------------------------------------------
   // Line store of top-row pixel pairs. An entry is written on the top
   // row and read a full source row later, at least two requests apart,
   // so the write has landed before the read and no forwarding is needed.
   // The column index stays below the store depth as the width saturates.
   // ------------------------------------------------------------------
   assign pair_addr = PAIR_AW'(col_ff >> 1);

   gcbd_ram #(
      .WIDTH (2 * PIX_W),
      .DEPTH (PAIR_DEPTH)
   ) u_pair_ram (
      .clock   (clock),
      .wr_en   (accept && store_top),
      .wr_addr (pair_addr),
      .wr_data ({req_src_pixel, left_ff}),
      .rd_en   (accept && produce),
      .rd_addr (pair_addr),
      .rd_data (pair_rd_data)
   );

   // read stage: advance when empty or when the encoder takes its content;
   // the RAM output holds with it, as reads are only issued on advance
   assign rd_acc = !rd_vld_ff || enc_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff <= 1'b0;
      end else if (rd_acc) begin
         rd_vld_ff <= accept && produce;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_acc) begin
         rd_left_ff  <= left_ff;
         rd_right_ff <= req_src_pixel;
         rd_last_ff  <= is_last;
      end
   end

   always_comb begin
      enc_quad.top_left  = pair_rd_data[PIX_W-1:0];
      enc_quad.top_right = pair_rd_data[2*PIX_W-1:PIX_W];
      enc_quad.bot_left  = rd_left_ff;
      enc_quad.bot_right = rd_right_ff;
      enc_quad.last      = rd_last_ff;
   end

   // ------------------------------------------------------------------
   // Linearise, average and re-encode
   // ------------------------------------------------------------------
   gcbd_encode u_encode (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (rd_vld_ff),
      .in_ready  (enc_ready),
      .in_quad   (enc_quad),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_pixel (rsp_out_pixel),
      .out_last  (rsp_frame_last)
   );

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Gamma-correct 2x2 downsampler testbench
// Streams RGBA8 source frames into the unit through the request channel and
// checks every downsampled pixel, field by field, against a directed table
// or an in-bench predictor with its own linear table, line store and raster
// counters. Frame sizes are set through the register port, read back, and
// varied from empty and odd shapes up to the saturated maximum, with idle
// and stall phases on both channels.
// ----------------------------------------------------------------------------
module testbench import gcbd_pkg::*; ();

   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int TAIL_CYCLES = 24;    // pipeline is 11 deep; leave margin
   localparam int HOLD_CYCLES = 600;
   localparam int PAIR_DEPTH  = DEF_MAX_WIDTH / 2;
   localparam int DIR_ROWS    = 20;

   // One row of the directed table. Where typed is set, the expectation is
   // taken from the row; otherwise the predictor supplies it.
   typedef struct packed {
      logic [PIX_W-1:0] pixel;
      logic             typed;
      logic             exp_valid;
      logic [PIX_W-1:0] exp_pixel;
      logic             exp_last;
   } stim_row_type;

   typedef struct packed {
      logic [PIX_W-1:0] pixel;
      logic             last;
   } down_px_type;

   // ------------------------------------------------------------------------
   // Clock, block and its ports
   // ------------------------------------------------------------------------
   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_ready;
   logic [PIX_W-1:0] req_src_pixel;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   logic [PIX_W-1:0] rsp_out_pixel;
   logic             rsp_frame_last;
   logic             csr_psel;
   logic             csr_penable;
   logic             csr_pwrite;
   logic [2:0]       csr_paddr;
   logic [31:0]      csr_pwdata;
   logic [31:0]      csr_prdata;
   logic             csr_pready;

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   gamma_correct_box_downsample_2x2_unit dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_src_pixel  (req_src_pixel),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_pixel  (rsp_out_pixel),
      .rsp_frame_last (rsp_frame_last),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready)
   );

   // ------------------------------------------------------------------------
   // Predictor state: its own copy of the sizes, counters and line store
   // ------------------------------------------------------------------------
   logic [LIN_W-1:0] lin_lut [0:255];
   int unsigned      cfg_width;
   int unsigned      cfg_height;
   logic [CFG_W-1:0] col_pos;
   logic [CFG_W-1:0] row_pos;
   logic [PIX_W-1:0] left_px;
   logic [63:0]      top_pairs [0:PAIR_DEPTH-1];

   down_px_type      pending_px [$];
   stim_row_type     dir_table [DIR_ROWS];

   // Idling controls, set by the main sequence per phase
   int               send_idle_pct  = 0;
   int               recv_stall_pct = 0;
   int               hold_seq       = 0;
   int               hold_seen      = 0;
   int               hold_left      = 0;

   int               mismatch_count = 0;
   int               csr_errs       = 0;
   int               cycle_count    = 0;

   function automatic logic [127:0] pow5(input logic [127:0] q);
      return q * q * q * q * q;
   endfunction

   // Start from a real-valued estimate of v^2.2 * 64, then nudge it until it
   // is the exact nearest integer: (2n-1)^5 <= 2^35 * v^11 < (2n+1)^5.
   task automatic build_lin_lut();
      logic [127:0] target;
      int           n;
      for (int v = 0; v < 256; v++) begin
         target = 128'd1;
         for (int i = 0; i < 11; i++) begin
            target = target * 128'(v);
         end
         target = target << 35;
         n = $rtoi($pow(real'(v), 2.2) * 64.0 + 0.5);
         while (pow5(128'(2 * n + 1)) <= target) begin
            n++;
         end
         while (n > 0 && pow5(128'(2 * n - 1)) > target) begin
            n--;
         end
         lin_lut[v] = LIN_W'(n);
      end
   endtask

   // Largest byte whose linear value, four times over, fits in the sum.
   function automatic logic [7:0] encode_gamma(input int unsigned sum);
      for (int k = 255; k >= 0; k--) begin
         if ((32'(lin_lut[k]) << 2) <= sum) begin
            return 8'(k);
         end
      end
      return 8'd0;
   endfunction

   function automatic void apply_size(input csr_reg_type sel, input logic [31:0] data);
      int unsigned v;
      v = 32'(data[CFG_W-1:0]);
      case (sel)
         REG_SRC_WIDTH: begin
            cfg_width = (v > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : v;
         end
         REG_SRC_HEIGHT: begin
            cfg_height = (v > MAX_HEIGHT) ? MAX_HEIGHT : v;
         end
         default: ;
      endcase
   endfunction

   // Advance the predictor by one source pixel; hit says a result is due.
   task automatic predict_downsample(input logic [PIX_W-1:0] pix, output logic hit,
                                     output down_px_type res);
      int unsigned      dw;
      int unsigned      dh;
      int unsigned      c;
      int unsigned      r;
      int unsigned      idx;
      int unsigned      s;
      int unsigned      asum;
      logic [PIX_W-1:0] tl;
      logic [PIX_W-1:0] tr;
      logic [PIX_W-1:0] acc;
      hit = 1'b0;
      res = '0;
      dw  = cfg_width / 2;
      dh  = cfg_height / 2;
      // an empty output frame swallows the pixel and moves nothing
      if (dw == 0 || dh == 0) begin
         return;
      end
      c = 32'(col_pos);
      r = 32'(row_pos);
      if (c < 2 * dw && r < 2 * dh) begin
         idx = c >> 1;
         if (!c[0]) begin
            left_px = pix;
         end else if (idx < PAIR_DEPTH) begin
            if (!r[0]) begin
               top_pairs[idx] = {pix, left_px};
            end else begin
               tl = top_pairs[idx][31:0];
               tr = top_pairs[idx][63:32];
               for (int ch = 0; ch < 3; ch++) begin
                  s = 32'(lin_lut[tl[8*ch +: 8]]) + 32'(lin_lut[tr[8*ch +: 8]])
                    + 32'(lin_lut[left_px[8*ch +: 8]]) + 32'(lin_lut[pix[8*ch +: 8]]);
                  acc[8*ch +: 8] = encode_gamma(s);
               end
               asum = 32'(tl[31:24]) + 32'(tr[31:24]) + 32'(left_px[31:24])
                    + 32'(pix[31:24]);
               acc[31:24] = 8'(asum >> 2);
               res.pixel  = acc;
               res.last   = (c == 2 * dw - 1 && r == 2 * dh - 1);
               hit        = 1'b1;
            end
         end
      end
      // counters wrap at the programmed size, so a shrunk size drops the rest
      c++;
      if (c >= cfg_width) begin
         c = 0;
         r++;
         if (r >= cfg_height) begin
            r = 0;
         end
      end
      col_pos = c[CFG_W-1:0];
      row_pos = r[CFG_W-1:0];
   endtask

   // ------------------------------------------------------------------------
   // Request side: offer one pixel, hold it until taken, then predict
   // ------------------------------------------------------------------------
   task automatic send_pixel(input stim_row_type row);
      logic        hit;
      down_px_type got;
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_src_pixel <= row.pixel;
      do @(posedge clock); while (!req_ready);
      predict_downsample(row.pixel, hit, got);
      if (row.typed) begin
         if (row.exp_valid) begin
            pending_px.push_back(down_px_type'({row.exp_pixel, row.exp_last}));
         end
      end else if (hit) begin
         pending_px.push_back(got);
      end
   endtask

   // Bias bytes towards the extremes so saturated corners get hit often.
   function automatic logic [PIX_W-1:0] rand_pixel();
      logic [PIX_W-1:0] p;
      for (int b = 0; b < 4; b++) begin
         case ($urandom_range(3))
            0:       p[8*b +: 8] = 8'h00;
            1:       p[8*b +: 8] = 8'hFF;
            default: p[8*b +: 8] = 8'($urandom);
         endcase
      end
      return p;
   endfunction

   task automatic send_random_pixels(input int count);
      stim_row_type row;
      for (int i = 0; i < count; i++) begin
         row       = '0;
         row.pixel = rand_pixel();
         send_pixel(row);
      end
   endtask

   // Drop valid, let every expected pixel arrive, then let the pipeline empty.
   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_px.size() != 0) begin
         @(posedge clock);
      end
      repeat (TAIL_CYCLES) @(posedge clock);
   endtask

   // ------------------------------------------------------------------------
   // Register port: setup cycle, access cycle, done when pready is high
   // ------------------------------------------------------------------------
   task automatic csr_cycle(input logic wr, input csr_reg_type sel,
                            input logic [31:0] wdata, output logic [31:0] rdata);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= {sel, 2'b00};
      csr_pwdata  <= wdata;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      if (wr) begin
         apply_size(sel, wdata);
      end
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic check_size_reg(input csr_reg_type sel);
      logic [31:0] rd;
      int unsigned want;
      csr_cycle(1'b0, sel, 32'h0, rd);
      want = (sel == REG_SRC_WIDTH) ? cfg_width : cfg_height;
      if (rd !== 32'(want)) begin
         csr_errs++;
         $display("%0t: %s read expected %0d, got %0d", $time, sel.name(), want, rd);
      end
   endtask

   task automatic write_size_reg(input csr_reg_type sel, input logic [31:0] data);
      logic [31:0] rd;
      wait_idle();
      csr_cycle(1'b1, sel, data, rd);
      check_size_reg(sel);
   endtask

   task automatic program_size(input logic [31:0] w_data, input logic [31:0] h_data);
      write_size_reg(REG_SRC_WIDTH, w_data);
      write_size_reg(REG_SRC_HEIGHT, h_data);
   endtask

   // Whole frames of random shape; empty shapes get a few ignored pixels.
   task automatic run_random_phase(input int sidle, input int rstall, input int quota);
      int sent;
      int w;
      int h;
      send_idle_pct  = sidle;
      recv_stall_pct = rstall;
      sent = 0;
      while (sent < quota) begin
         w = $urandom_range(0, 9);
         h = $urandom_range(0, 9);
         if ($urandom_range(7) == 0) begin
            w = $urandom_range(10, 33);
            h = $urandom_range(2, 4);
         end
         // upper data bits are don't-care; toggle them anyway
         program_size({19'($urandom), 13'(w)}, {19'($urandom), 13'(h)});
         if (w < 2 || h < 2) begin
            send_random_pixels($urandom_range(1, 4));
         end else begin
            repeat ($urandom_range(1, 2)) begin
               send_random_pixels(w * h);
               sent += w * h;
            end
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // Result side: random stalls, plus a long hold-off on request
   // ------------------------------------------------------------------------
   always @(negedge clock) begin
      if (hold_seq != hold_seen) begin
         hold_seen = hold_seq;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Compare each downsampled pixel with the oldest expectation.
   always @(posedge clock) begin : rsp_check
      down_px_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_px.size() == 0) begin
            mismatch_count++;
            $display("%0t: expected no pixel, got %08h frame_last %0b",
                     $time, rsp_out_pixel, rsp_frame_last);
         end else begin
            want = pending_px.pop_front();
            if (rsp_out_pixel !== want.pixel) begin
               mismatch_count++;
               $display("%0t: out_pixel expected %08h, got %08h",
                        $time, want.pixel, rsp_out_pixel);
            end
            if (rsp_frame_last !== want.last) begin
               mismatch_count++;
               $display("%0t: frame_last expected %0b, got %0b",
                        $time, want.last, rsp_frame_last);
            end
         end
      end
   end

   // Watchdog: end the run if it drags on far beyond a correct run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------------
   initial begin
      // drive every input to a known level before the first edge
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_src_pixel = '0;
      csr_psel      = 1'b0;
      csr_penable   = 1'b0;
      csr_pwrite    = 1'b0;
      csr_paddr     = '0;
      csr_pwdata    = '0;

      build_lin_lut();
      cfg_width  = 0;
      cfg_height = 0;
      col_pos    = '0;
      row_pos    = '0;
      left_px    = '0;

      // Directed blocks of a 2x2 frame, one output pixel per four requests.
      // Uniform blocks must come back unchanged; the checkerboard goes to
      // the predictor, and alpha FF, FF, FF, FE must average down to FE.
      dir_table = '{
         '{32'h0000_0000, 1'b1, 1'b0, 32'h0000_0000, 1'b0},
         '{32'h0000_0000, 1'b1, 1'b0, 32'h0000_0000, 1'b0},
         '{32'h0000_0000, 1'b1, 1'b0, 32'h0000_0000, 1'b0},
         '{32'h0000_0000, 1'b1, 1'b1, 32'h0000_0000, 1'b1},
         '{32'hFFFF_FFFF, 1'b1, 1'b0, 32'h0000_0000, 1'b0},
         '{32'hFFFF_FFFF, 1'b1, 1'b0, 32'h0000_0000, 1'b0},
         '{32'hFFFF_FFFF, 1'b1, 1'b0, 32'h0000_0000, 1'b0},
         '{32'hFFFF_FFFF, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b1},
         '{32'h8040_2010, 1'b1, 1'b0, 32'h0000_0000, 1'b0},
         '{32'h8040_2010, 1'b1, 1'b0, 32'h0000_0000, 1'b0},
         '{32'h8040_2010, 1'b1, 1'b0, 32'h0000_0000, 1'b0},
         '{32'h8040_2010, 1'b1, 1'b1, 32'h8040_2010, 1'b1},
         '{32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0000_0000, 1'b0},
         '{32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000, 1'b0},
         '{32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000, 1'b0},
         '{32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0000_0000, 1'b0},
         '{32'hFF00_0000, 1'b1, 1'b0, 32'h0000_0000, 1'b0},
         '{32'hFF00_0000, 1'b1, 1'b0, 32'h0000_0000, 1'b0},
         '{32'hFF00_0000, 1'b1, 1'b0, 32'h0000_0000, 1'b0},
         '{32'hFE00_0000, 1'b1, 1'b1, 32'hFE00_0000, 1'b1}
      };

      // hold reset, then release it on a falling edge
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // both size registers must come out of reset as zero
      check_size_reg(REG_SRC_WIDTH);
      check_size_reg(REG_SRC_HEIGHT);

      // directed table under a 2x2 frame
      program_size(32'd2, 32'd2);
      foreach (dir_table[i]) begin
         send_pixel(dir_table[i]);
      end

      // empty output frames: zero width, then a single row
      program_size(32'd0, 32'd5);
      send_random_pixels(2);
      program_size(32'd6, 32'd1);
      send_random_pixels(2);

      // Shrink the height mid-frame with the row counter beyond the new size:
      // the rest of that row is consumed silently, then a fresh frame follows.
      program_size(32'd4, 32'd8);
      send_random_pixels(16);
      write_size_reg(REG_SRC_HEIGHT, 32'd2);
      send_random_pixels(12);

      // Shrink the width part-way through a top row: the column counter wraps
      // straight into the bottom row, which reads pairs already stored.
      program_size(32'd8, 32'd2);
      send_random_pixels(6);
      write_size_reg(REG_SRC_WIDTH, 32'd4);
      send_random_pixels(5);

      // Back-pressure: hold the result side off for a long stretch while
      // requests keep coming, so the unit fills and stalls its input.
      program_size(32'd8, 32'd16);
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_seq++;
      send_random_pixels(8 * 16);

      // random frames under each idling pattern
      run_random_phase(0, 0, 50);
      run_random_phase(60, 0, 50);
      run_random_phase(0, 60, 50);
      run_random_phase(13, 13, 50);

      // Largest sizes, both reached by saturation: the top rows of a narrow
      // frame at full height, then the full width, which leaves the row
      // counter beyond the new height so the last requests give nothing.
      program_size(32'd2, 32'hFFFF_1001);
      send_random_pixels(8);
      program_size(32'hFFFF_FFFF, 32'd2);
      send_random_pixels(4);

      // drain and report
      wait_idle();
      if (mismatch_count == 0 && csr_errs == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
